FILE: hw/rtl/tkm_pkg.sv
`timescale 1ns / 1ps

package tkm_pkg;

	localparam int LIST_DEPTH = 16;
	localparam int COORD_BITS = 12;

	localparam int IDX_BITS = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int COUNT_BITS = $clog2(LIST_DEPTH + 1);

	localparam int COST_BITS = 16;
	localparam int TPL_BITS = 8;
	localparam int SLOT_BITS = 4;
	localparam int LIMIT_BITS = 5;
	localparam int SUPP_BITS = 13;
	localparam int OUTCOME_BITS = 3;
	localparam int CFG_DATA_BITS = 13;
	localparam int CFG_INDEX_BITS = 1;

	// |dx| + |dy| needs one bit more than a coordinate
	localparam int DIST_BITS = (COORD_BITS + 1 > SUPP_BITS) ? COORD_BITS + 1 : SUPP_BITS;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_LIST_LIMIT = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SUPPRESS   = 1'b1;

	localparam logic MODE_READ = 1'b1;

	typedef enum logic [OUTCOME_BITS-1:0] {
		OUT_INSERTED = 3'd0,
		OUT_REPLACED = 3'd1,
		OUT_KEPT     = 3'd2,
		OUT_DROPPED  = 3'd3,
		OUT_READ     = 3'd4
	} outcome_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DECIDE,
		ST_APPLY,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic [COST_BITS-1:0]  cost;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [TPL_BITS-1:0]   tpl;
	} entry_t;

	typedef struct packed {
		logic load_in;
		logic eval;
		logic decide;
		logic apply;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic is_read;
	} status_t;

endpackage

FILE: hw/rtl/top_k_match_list_suppress.sv
`timescale 1ns / 1ps

// Sorted list of the best candidate matches (ascending cost) with suppression of near
// neighbours, held in a register file of tkm_pkg::LIST_DEPTH entries. An accepted
// candidate is captured, then the compare step checks distance and cost against all
// entries in parallel, the decide step selects the absorbing entry or the insertion
// point, the apply step shifts the entries and writes the candidate, and the result
// register is loaded once the output is free. A read skips decide and apply. The
// sequencer works on one item at a time, so the input stalls until the item's result
// is loaded; the result register lets the next item be taken while a result is still
// held under out_stall. Configuration (index 0 list_limit, index 1 suppress_distance)
// is to be written through cfg_we/cfg_index/cfg_data only while no item is in
// progress; the block itself does not enforce this.
module top_k_match_list_suppress (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tkm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [tkm_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                mode,
	input  logic [tkm_pkg::COST_BITS-1:0]       cand_cost,
	input  logic [tkm_pkg::COORD_BITS-1:0]      pos_x,
	input  logic [tkm_pkg::COORD_BITS-1:0]      pos_y,
	input  logic [tkm_pkg::TPL_BITS-1:0]        template_id,
	input  logic [tkm_pkg::SLOT_BITS-1:0]       read_slot,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [tkm_pkg::OUTCOME_BITS-1:0]    outcome,
	output logic [tkm_pkg::SLOT_BITS-1:0]       slot,
	output logic                                entry_valid,
	output logic [tkm_pkg::COST_BITS-1:0]       entry_cost,
	output logic [tkm_pkg::COORD_BITS-1:0]      entry_x,
	output logic [tkm_pkg::COORD_BITS-1:0]      entry_y,
	output logic [tkm_pkg::TPL_BITS-1:0]        entry_template,
	output logic [tkm_pkg::LIMIT_BITS-1:0]      entry_count
);

	tkm_pkg::cmd_t    cmd;
	tkm_pkg::status_t status;

	tkm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	tkm_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mode           (mode),
		.cand_cost      (cand_cost),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.template_id    (template_id),
		.read_slot      (read_slot),
		.cmd            (cmd),
		.status         (status),
		.outcome        (outcome),
		.slot           (slot),
		.entry_valid    (entry_valid),
		.entry_cost     (entry_cost),
		.entry_x        (entry_x),
		.entry_y        (entry_y),
		.entry_template (entry_template),
		.entry_count    (entry_count)
	);

endmodule

FILE: hw/rtl/tkm_ctrl.sv
`timescale 1ns / 1ps

module tkm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  tkm_pkg::status_t status,
	output tkm_pkg::cmd_t    cmd
);

	tkm_pkg::state_t state_q;
	tkm_pkg::state_t state_nxt;
	logic            out_valid_q;
	logic            out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != tkm_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tkm_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		unique case (state_q)
			tkm_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_nxt = tkm_pkg::ST_EVAL;
				end
			end
			tkm_pkg::ST_EVAL: begin
				cmd.eval = 1'b1;
				state_nxt = status.is_read ? tkm_pkg::ST_RESULT : tkm_pkg::ST_DECIDE;
			end
			tkm_pkg::ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_nxt = tkm_pkg::ST_APPLY;
			end
			tkm_pkg::ST_APPLY: begin
				cmd.apply = 1'b1;
				state_nxt = tkm_pkg::ST_RESULT;
			end
			tkm_pkg::ST_RESULT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_nxt = tkm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = tkm_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	a_accept_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == tkm_pkg::ST_EVAL)
		else $error("accepted item did not enter compare step");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !out_valid_q || !out_stall)
		else $error("pending result overwritten");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tkm_pkg::ST_RESULT && out_free |=> out_valid_q)
		else $error("result not presented");

	a_apply_after_decide: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tkm_pkg::ST_APPLY |-> $past(state_q) == tkm_pkg::ST_DECIDE)
		else $error("list update without a decision");

endmodule

FILE: hw/rtl/tkm_datapath.sv
`timescale 1ns / 1ps

module tkm_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tkm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [tkm_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic                                mode,
	input  logic [tkm_pkg::COST_BITS-1:0]       cand_cost,
	input  logic [tkm_pkg::COORD_BITS-1:0]      pos_x,
	input  logic [tkm_pkg::COORD_BITS-1:0]      pos_y,
	input  logic [tkm_pkg::TPL_BITS-1:0]        template_id,
	input  logic [tkm_pkg::SLOT_BITS-1:0]       read_slot,
	input  tkm_pkg::cmd_t                       cmd,
	output tkm_pkg::status_t                    status,
	output logic [tkm_pkg::OUTCOME_BITS-1:0]    outcome,
	output logic [tkm_pkg::SLOT_BITS-1:0]       slot,
	output logic                                entry_valid,
	output logic [tkm_pkg::COST_BITS-1:0]       entry_cost,
	output logic [tkm_pkg::COORD_BITS-1:0]      entry_x,
	output logic [tkm_pkg::COORD_BITS-1:0]      entry_y,
	output logic [tkm_pkg::TPL_BITS-1:0]        entry_template,
	output logic [tkm_pkg::LIMIT_BITS-1:0]      entry_count
);

	tkm_pkg::entry_t list_q [tkm_pkg::LIST_DEPTH];

	logic [tkm_pkg::COUNT_BITS-1:0] held_q;
	logic [tkm_pkg::COUNT_BITS-1:0] lim_q;
	logic [tkm_pkg::SUPP_BITS-1:0]  supp_q;

	tkm_pkg::entry_t               cand_q;
	logic                          mode_q;
	logic [tkm_pkg::SLOT_BITS-1:0] rslot_q;

	logic [tkm_pkg::LIST_DEPTH-1:0] near_s1;
	logic [tkm_pkg::LIST_DEPTH-1:0] le_s1;
	logic [tkm_pkg::LIST_DEPTH-1:0] lt_s1;

	tkm_pkg::outcome_t            op_s2;
	logic [tkm_pkg::IDX_BITS-1:0] lo_s2;
	logic [tkm_pkg::IDX_BITS-1:0] hi_s2;
	logic                         grow_s2;

	tkm_pkg::outcome_t               outcome_q;
	logic [tkm_pkg::SLOT_BITS-1:0]   slot_q;
	logic                            valid_q;
	tkm_pkg::entry_t                 entry_q;
	logic [tkm_pkg::LIMIT_BITS-1:0]  count_q;

	// configuration
	logic [tkm_pkg::LIMIT_BITS-1:0] cfg_lim;
	logic [tkm_pkg::COUNT_BITS-1:0] eff_lim;

	assign cfg_lim = cfg_data[tkm_pkg::LIMIT_BITS-1:0];

	always_comb begin
		if (cfg_lim == '0) begin
			eff_lim = tkm_pkg::COUNT_BITS'(1);
		end else if (cfg_lim > tkm_pkg::LIST_DEPTH) begin
			eff_lim = tkm_pkg::COUNT_BITS'(tkm_pkg::LIST_DEPTH);
		end else begin
			eff_lim = tkm_pkg::COUNT_BITS'(cfg_lim);
		end
	end

	logic cfg_lim_wr;
	assign cfg_lim_wr = cfg_we && (cfg_index == tkm_pkg::CFG_LIST_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q  <= tkm_pkg::COUNT_BITS'(tkm_pkg::LIST_DEPTH);
			supp_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tkm_pkg::CFG_LIST_LIMIT: lim_q  <= eff_lim;
				tkm_pkg::CFG_SUPPRESS:   supp_q <= cfg_data[tkm_pkg::SUPP_BITS-1:0];
				default: ;
			endcase
		end
	end

	// fill count; a lowered limit discards the tail at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (cfg_lim_wr) begin
			if (held_q > eff_lim) begin
				held_q <= eff_lim;
			end
		end else if (cmd.apply && op_s2 == tkm_pkg::OUT_INSERTED && grow_s2) begin
			held_q <= held_q + tkm_pkg::COUNT_BITS'(1);
		end
	end

	// candidate capture
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cand_q.cost <= cand_cost;
			cand_q.x    <= pos_x;
			cand_q.y    <= pos_y;
			cand_q.tpl  <= template_id;
			mode_q      <= mode;
			rslot_q     <= read_slot;
		end
	end

	assign status.is_read = (mode_q == tkm_pkg::MODE_READ);

	// compare step: distance and cost against every entry in parallel
	logic [tkm_pkg::LIST_DEPTH-1:0] near_c;
	logic [tkm_pkg::LIST_DEPTH-1:0] le_c;
	logic [tkm_pkg::LIST_DEPTH-1:0] lt_c;

	always_comb begin
		logic [tkm_pkg::COORD_BITS-1:0] dx;
		logic [tkm_pkg::COORD_BITS-1:0] dy;
		logic [tkm_pkg::DIST_BITS-1:0]  l1_sum;
		for (int i = 0; i < tkm_pkg::LIST_DEPTH; i++) begin
			dx = (list_q[i].x >= cand_q.x) ? list_q[i].x - cand_q.x : cand_q.x - list_q[i].x;
			dy = (list_q[i].y >= cand_q.y) ? list_q[i].y - cand_q.y : cand_q.y - list_q[i].y;
			l1_sum = tkm_pkg::DIST_BITS'(dx) + tkm_pkg::DIST_BITS'(dy);
			near_c[i] = (tkm_pkg::COUNT_BITS'(i) < held_q) &&
				(l1_sum < tkm_pkg::DIST_BITS'(supp_q));
			le_c[i] = (list_q[i].cost <= cand_q.cost);
			lt_c[i] = (list_q[i].cost < cand_q.cost);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			near_s1 <= near_c;
			le_s1   <= le_c;
			lt_s1   <= lt_c;
		end
	end

	// decide step: priority encoders over the compare vectors
	logic [tkm_pkg::IDX_BITS-1:0]   near_idx;
	logic                           near_found;
	logic [tkm_pkg::IDX_BITS-1:0]   bub_idx;
	logic [tkm_pkg::COUNT_BITS-1:0] ins_pos;
	logic                           full;
	logic [tkm_pkg::IDX_BITS-1:0]   last_idx;
	logic                           drop;
	logic [tkm_pkg::IDX_BITS-1:0]   hi_ins;

	always_comb begin
		near_idx   = '0;
		near_found = 1'b0;
		bub_idx    = '0;
		ins_pos    = held_q;
		for (int i = tkm_pkg::LIST_DEPTH - 1; i >= 0; i--) begin
			if (near_s1[i]) begin
				near_idx   = tkm_pkg::IDX_BITS'(i);
				near_found = 1'b1;
			end
			// list is sorted, so the first costlier entry is where a cheaper one lands
			if (!le_s1[i] && tkm_pkg::COUNT_BITS'(i) < held_q) begin
				bub_idx = tkm_pkg::IDX_BITS'(i);
			end
			if (!lt_s1[i] && tkm_pkg::COUNT_BITS'(i) < held_q) begin
				ins_pos = tkm_pkg::COUNT_BITS'(i);
			end
		end
		full     = (held_q >= lim_q);
		last_idx = tkm_pkg::IDX_BITS'(lim_q - tkm_pkg::COUNT_BITS'(1));
		drop     = full && lt_s1[last_idx];
		hi_ins   = full ? last_idx : tkm_pkg::IDX_BITS'(held_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			grow_s2 <= 1'b0;
			if (near_found) begin
				if (!le_s1[near_idx]) begin
					op_s2 <= tkm_pkg::OUT_REPLACED;
					lo_s2 <= bub_idx;
					hi_s2 <= near_idx;
				end else begin
					op_s2 <= tkm_pkg::OUT_KEPT;
					lo_s2 <= near_idx;
					hi_s2 <= near_idx;
				end
			end else if (drop) begin
				op_s2 <= tkm_pkg::OUT_DROPPED;
				lo_s2 <= '0;
				hi_s2 <= '0;
			end else begin
				op_s2   <= tkm_pkg::OUT_INSERTED;
				lo_s2   <= tkm_pkg::IDX_BITS'(ins_pos);
				hi_s2   <= hi_ins;
				grow_s2 <= !full;
			end
		end
	end

	// apply step: on insert or replace, the candidate goes to lo, entries in (lo, hi] move down one place
	logic do_write;
	assign do_write = cmd.apply &&
		(op_s2 == tkm_pkg::OUT_INSERTED || op_s2 == tkm_pkg::OUT_REPLACED);

	for (genvar m = 0; m < tkm_pkg::LIST_DEPTH; m++) begin : g_entry
		if (m == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (do_write && lo_s2 == '0) begin
					list_q[m] <= cand_q;
				end
			end
		end else begin : g_body
			always_ff @(posedge clk) begin
				if (do_write) begin
					if (tkm_pkg::IDX_BITS'(m) == lo_s2) begin
						list_q[m] <= cand_q;
					end else if (tkm_pkg::IDX_BITS'(m) > lo_s2 &&
						tkm_pkg::IDX_BITS'(m) <= hi_s2) begin
						list_q[m] <= list_q[m-1];
					end
				end
			end
		end
	end

	// result register
	logic [tkm_pkg::IDX_BITS-1:0] rep_idx;
	tkm_pkg::entry_t              rep_entry;
	logic                         rep_valid;

	assign rep_idx   = status.is_read ? tkm_pkg::IDX_BITS'(rslot_q) : lo_s2;
	assign rep_entry = list_q[rep_idx];
	assign rep_valid = status.is_read ? (rslot_q < held_q) : (op_s2 != tkm_pkg::OUT_DROPPED);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			outcome_q <= status.is_read ? tkm_pkg::OUT_READ : op_s2;
			slot_q    <= status.is_read ? rslot_q : tkm_pkg::SLOT_BITS'(lo_s2);
			valid_q   <= rep_valid;
			entry_q   <= rep_valid ? rep_entry : '0;
			count_q   <= tkm_pkg::LIMIT_BITS'(held_q);
		end
	end

	assign outcome        = outcome_q;
	assign slot           = slot_q;
	assign entry_valid    = valid_q;
	assign entry_cost     = entry_q.cost;
	assign entry_x        = entry_q.x;
	assign entry_y        = entry_q.y;
	assign entry_template = entry_q.tpl;
	assign entry_count    = count_q;

endmodule

FILE: dv/top_k_match_list_suppress_tb.sv
`timescale 1ns / 1ps

module top_k_match_list_suppress_tb;

	import tkm_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int HOLD_CYCLES = 80;

	typedef struct {
		logic                  mode;
		logic [COST_BITS-1:0]  cost;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [TPL_BITS-1:0]   tpl;
		logic [SLOT_BITS-1:0]  rslot;
	} cand_t;

	typedef struct {
		outcome_t              oc;
		logic [SLOT_BITS-1:0]  slot;
		logic                  valid;
		logic [COST_BITS-1:0]  cost;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [TPL_BITS-1:0]   tpl;
		logic [LIMIT_BITS-1:0] count;
	} verdict_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;
	logic                      in_valid;
	logic                      in_stall;
	logic                      mode;
	logic [COST_BITS-1:0]      cand_cost;
	logic [COORD_BITS-1:0]     pos_x;
	logic [COORD_BITS-1:0]     pos_y;
	logic [TPL_BITS-1:0]       template_id;
	logic [SLOT_BITS-1:0]      read_slot;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [OUTCOME_BITS-1:0]   outcome;
	logic [SLOT_BITS-1:0]      slot;
	logic                      entry_valid;
	logic [COST_BITS-1:0]      entry_cost;
	logic [COORD_BITS-1:0]     entry_x;
	logic [COORD_BITS-1:0]     entry_y;
	logic [TPL_BITS-1:0]       entry_template;
	logic [LIMIT_BITS-1:0]     entry_count;

	top_k_match_list_suppress u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mode           (mode),
		.cand_cost      (cand_cost),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.template_id    (template_id),
		.read_slot      (read_slot),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.outcome        (outcome),
		.slot           (slot),
		.entry_valid    (entry_valid),
		.entry_cost     (entry_cost),
		.entry_x        (entry_x),
		.entry_y        (entry_y),
		.entry_template (entry_template),
		.entry_count    (entry_count)
	);

	// shadow of the match list
	entry_t                ranked[LIST_DEPTH];
	int                    held;
	logic [LIMIT_BITS-1:0] limit_reg;
	logic [SUPP_BITS-1:0]  supp_reg;

	verdict_t pending_verdicts[$];

	int error_count;
	int offers_sent;
	int reads_sent;
	int settings_used;
	int outcome_seen[5];
	int tx_idle_pct;
	int rx_idle_pct;
	int idle_cycles;
	int hold_asks;
	int hold_taken;
	int hold_left;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int list_cap();
		if (limit_reg == 0)
			return 1;
		if (limit_reg > LIST_DEPTH)
			return LIST_DEPTH;
		return int'(limit_reg);
	endfunction

	function automatic verdict_t describe(outcome_t oc, int s, bit ok, int idx);
		verdict_t v;
		v.oc = oc;
		v.slot = SLOT_BITS'(s);
		v.valid = ok;
		if (ok) begin
			v.cost = ranked[idx].cost;
			v.x = ranked[idx].x;
			v.y = ranked[idx].y;
			v.tpl = ranked[idx].tpl;
		end else begin
			v.cost = '0;
			v.x = '0;
			v.y = '0;
			v.tpl = '0;
		end
		v.count = LIMIT_BITS'(held);
		return v;
	endfunction

	function automatic verdict_t rank_candidate(cand_t c);
		int lim;
		int i;
		int j;
		int k;
		int dx;
		int dy;
		entry_t t;
		lim = list_cap();
		if (c.mode == MODE_READ)
			return describe(OUT_READ, int'(c.rslot), int'(c.rslot) < held, int'(c.rslot));
		for (i = 0; i < held; i++) begin
			dx = int'(ranked[i].x) - int'(c.x);
			dy = int'(ranked[i].y) - int'(c.y);
			if (dx < 0)
				dx = -dx;
			if (dy < 0)
				dy = -dy;
			if (dx + dy < int'(supp_reg)) begin
				if (c.cost < ranked[i].cost) begin
					ranked[i] = '{cost: c.cost, x: c.x, y: c.y, tpl: c.tpl};
					k = i;
					while (k > 0 && ranked[k-1].cost > ranked[k].cost) begin
						t = ranked[k-1];
						ranked[k-1] = ranked[k];
						ranked[k] = t;
						k--;
					end
					return describe(OUT_REPLACED, k, 1'b1, k);
				end
				return describe(OUT_KEPT, i, 1'b1, i);
			end
		end
		if (held >= lim) begin
			if (ranked[lim-1].cost < c.cost)
				return describe(OUT_DROPPED, 0, 1'b0, 0);
			held = lim;
		end
		// ties go in front of existing entries of equal cost
		j = 0;
		while (j < held && ranked[j].cost < c.cost)
			j++;
		k = (held < lim) ? held : lim - 1;
		while (k > j) begin
			ranked[k] = ranked[k-1];
			k--;
		end
		ranked[j] = '{cost: c.cost, x: c.x, y: c.y, tpl: c.tpl};
		if (held < lim)
			held++;
		return describe(OUT_INSERTED, j, 1'b1, j);
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			error_count++;
			$display("%0t ns: %s mismatch, expected 0x%h, got 0x%h", $time, name, want, got);
		end
	endtask

	// result side: compare every accepted item against the oldest prediction
	always @(posedge clk) begin
		verdict_t v;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_verdicts.size() == 0) begin
				error_count++;
				$display("%0t ns: result with none expected, outcome 0x%h slot 0x%h",
					$time, outcome, slot);
			end else begin
				v = pending_verdicts.pop_front();
				outcome_seen[int'(v.oc)]++;
				check_field("outcome", 16'(v.oc), 16'(outcome));
				check_field("slot", 16'(v.slot), 16'(slot));
				check_field("entry_valid", 16'(v.valid), 16'(entry_valid));
				check_field("entry_cost", v.cost, entry_cost);
				check_field("entry_x", 16'(v.x), 16'(entry_x));
				check_field("entry_y", 16'(v.y), 16'(entry_y));
				check_field("entry_template", 16'(v.tpl), 16'(entry_template));
				check_field("entry_count", 16'(v.count), 16'(entry_count));
			end
		end
	end

	// receiver: random stalls, plus a long hold-off when one is asked for
	always @(posedge clk) begin
		if (hold_asks != hold_taken) begin
			hold_taken = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_stall === 1'b0) ||
				(out_valid === 1'b1 && out_stall === 1'b0))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t ns: no item moved for %0d cycles", $time, STALL_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_item(input cand_t c);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= c.mode;
		cand_cost <= c.cost;
		pos_x <= c.x;
		pos_y <= c.y;
		template_id <= c.tpl;
		read_slot <= c.rslot;
		do @(posedge clk); while (in_stall !== 1'b0);
		pending_verdicts = {pending_verdicts, rank_candidate(c)};
		if (c.mode == MODE_READ)
			reads_sent++;
		else
			offers_sent++;
	endtask

	task automatic offer(input int cost, input int x, input int y, input int tpl);
		cand_t c;
		c = '{mode: ~MODE_READ, cost: COST_BITS'(cost), x: COORD_BITS'(x),
			y: COORD_BITS'(y), tpl: TPL_BITS'(tpl), rslot: '0};
		send_item(c);
	endtask

	task automatic read_at(input int s);
		cand_t c;
		c = '{mode: MODE_READ, cost: '0, x: '0, y: '0, tpl: '0, rslot: SLOT_BITS'(s)};
		send_item(c);
	endtask

	// lets every outstanding item come back before the block is touched
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == CFG_LIST_LIMIT) begin
			limit_reg = value[LIMIT_BITS-1:0];
			if (held > list_cap())
				held = list_cap();
		end else begin
			supp_reg = value[SUPP_BITS-1:0];
		end
		settings_used++;
	endtask

	function automatic cand_t random_cand(int read_pct);
		cand_t c;
		int bx;
		int by;
		c.mode = ($urandom_range(0, 99) < read_pct) ? MODE_READ : ~MODE_READ;
		if ($urandom_range(0, 3) == 0 || held == 0)
			c.rslot = SLOT_BITS'($urandom_range(0, 15));
		else
			c.rslot = SLOT_BITS'($urandom_range(0, held - 1));
		c.tpl = TPL_BITS'($urandom);
		case ($urandom_range(0, 3))
			0: c.cost = COST_BITS'($urandom_range(0, 7) << 12);
			1: c.cost = COST_BITS'($urandom_range(0, 255));
			default: c.cost = COST_BITS'($urandom);
		endcase
		// most candidates land near a few hot spots so that merging happens
		case ($urandom_range(0, 3))
			0: begin bx = 16; by = 16; end
			1: begin bx = 2000; by = 3000; end
			2: begin bx = 4000; by = 40; end
			default: begin bx = 1024; by = 2048; end
		endcase
		if ($urandom_range(0, 3) == 0) begin
			c.x = COORD_BITS'($urandom);
			c.y = COORD_BITS'($urandom);
		end else begin
			c.x = COORD_BITS'(bx + $urandom_range(0, 40));
			c.y = COORD_BITS'(by + $urandom_range(0, 40));
		end
		return c;
	endfunction

	task automatic test_empty_reads();
		read_at(0);
		read_at(15);
		drain_results();
	endtask

	task automatic test_sorted_insert();
		offer(16'hFFFF, 4095, 4095, 255);
		offer(0, 0, 0, 0);
		offer(16'h1000, 10, 10, 1);
		offer(16'h1000, 20, 20, 2);
		read_at(0);
		read_at(2);
		read_at(3);
		read_at(4);
		drain_results();
	endtask

	task automatic test_full_list();
		// cuts the four held entries down to two
		write_reg(CFG_LIST_LIMIT, 2);
		offer(16'h2000, 500, 500, 3);
		offer(16'h1000, 30, 30, 4);
		read_at(1);
		read_at(2);
		drain_results();
	endtask

	task automatic test_suppression();
		write_reg(CFG_LIST_LIMIT, 16);
		write_reg(CFG_SUPPRESS, 8191);
		offer(5, 4095, 4095, 6);
		drain_results();
		write_reg(CFG_SUPPRESS, 50);
		offer(16'h0800, 2000, 2000, 7);
		offer(16'h0100, 2005, 2005, 8);
		// absorbed by the last entry, then bubbles one place up
		offer(0, 31, 31, 9);
		read_at(0);
		read_at(1);
		read_at(2);
		drain_results();
	endtask

	task automatic test_limit_edges();
		write_reg(CFG_LIST_LIMIT, 0);
		offer(16'hFFFF, 3000, 100, 10);
		read_at(0);
		drain_results();
		write_reg(CFG_LIST_LIMIT, 31);
		offer(16'h0300, 3500, 900, 11);
		read_at(15);
		drain_results();
	endtask

	task automatic test_random_mix();
		int lims[8] = '{16, 1, 4, 0, 31, 8, 2, 12};
		int supps[8] = '{0, 8191, 40, 100, 300, 20, 5, 1000};
		for (int p = 0; p < 8; p++) begin
			drain_results();
			write_reg(CFG_LIST_LIMIT, CFG_DATA_BITS'(lims[p]));
			write_reg(CFG_SUPPRESS, CFG_DATA_BITS'(supps[p]));
			repeat (180) send_item(random_cand(20));
		end
		drain_results();
	endtask

	task automatic test_no_idle();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_reg(CFG_LIST_LIMIT, 16);
		write_reg(CFG_SUPPRESS, 30);
		repeat (300) send_item(random_cand(15));
		drain_results();
		tx_idle_pct = 8;
		rx_idle_pct = 8;
	endtask

	task automatic test_backpressure();
		write_reg(CFG_LIST_LIMIT, 6);
		write_reg(CFG_SUPPRESS, 60);
		tx_idle_pct = 0;
		hold_asks++;
		repeat (40) send_item(random_cand(20));
		drain_results();
		tx_idle_pct = 8;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		mode = 1'b0;
		cand_cost = '0;
		pos_x = '0;
		pos_y = '0;
		template_id = '0;
		read_slot = '0;
		tx_idle_pct = 8;
		rx_idle_pct = 8;
		held = 0;
		limit_reg = LIMIT_BITS'(16);
		supp_reg = '0;
		foreach (ranked[i])
			ranked[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_reads();
		test_sorted_insert();
		test_full_list();
		test_suppression();
		test_limit_edges();
		test_random_mix();
		test_backpressure();
		test_no_idle();

		drain_results();
		repeat (20) @(posedge clk);
		$display("Ran %0d offers and %0d reads across %0d register writes",
			offers_sent, reads_sent, settings_used);
		$display("Outcomes: inserted %0d, replaced %0d, kept %0d, dropped %0d, read %0d",
			outcome_seen[0], outcome_seen[1], outcome_seen[2], outcome_seen[3],
			outcome_seen[4]);
		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", error_count);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/tkm_pkg.sv
hw/rtl/tkm_ctrl.sv
hw/rtl/tkm_datapath.sv
hw/rtl/top_k_match_list_suppress.sv
dv/top_k_match_list_suppress_tb.sv
